// ===== hdl/cwd_pkg.sv =====
// Package with shared constants, types and command structs for the cylinder wall distance block.
package cwd_pkg;
	localparam int unsigned MaxMarchDefault = 65535;
	localparam logic [14:0] RadiusReset = 15'd16900;
	localparam logic [14:0] HalfHeightReset = 15'd18100;
	localparam logic [7:0] CoarseReset = 8'd10;
	localparam logic [7:0] FineReset = 8'd1;
	localparam logic [16:0] OutSat = 17'd65535;
	localparam logic [1:0] RegRadius = 2'd0;
	localparam logic [1:0] RegHalfHeight = 2'd1;
	localparam logic [1:0] RegCoarse = 2'd2;
	localparam logic [1:0] RegFine = 2'd3;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic wall_calc;
		logic sample;
		logic sel_fine;
		logic step_coarse;
		logic step_fine;
		logic set_fine_base;
		logic set_nofind;
		logic emit;
	} cwd_cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic outside;
		logic sample_out;
		logic sample_ready;
		logic t_limit;
	} cwd_stat_t;
endpackage

// ===== hdl/cwd_datapath.sv =====
// Datapath: vertex registers, square root unit, ray sample tester and result registers.
module cwd_datapath #(
	parameter int unsigned MAX_MARCH_MM = cwd_pkg::MaxMarchDefault,
	parameter int unsigned TW = $clog2(MAX_MARCH_MM + 256) + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cwd_pkg::cwd_cmd_t  cmd,
	output cwd_pkg::cwd_stat_t stat,
	input  logic [14:0]        radius_mm,
	input  logic [14:0]        half_height_mm,
	input  logic [7:0]         coarse_step_mm,
	input  logic [7:0]         fine_step_mm,
	input  logic signed [16:0] pos_x,
	input  logic signed [16:0] pos_y,
	input  logic signed [16:0] pos_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic               strobe,
	output logic signed [16:0] wall_dist,
	output logic signed [16:0] ray_dist,
	output logic               is_outside
);
	import cwd_pkg::*;

	localparam int PW = 33 + TW;
	localparam logic [TW-1:0] TMax = TW'(MAX_MARCH_MM);

	logic signed [16:0] px_q, py_q, pz_q;
	logic signed [15:0] dx_q, dy_q, dz_q;
	logic [33:0] s_q, rem_q;
	logic [16:0] root_q;
	logic [4:0]  sq_cnt_q;
	logic        outside_q;
	logic [TW-1:0] t_q, base_q, tp_q;
	logic [7:0]  c_eff, f_eff;
	logic [1:0]  smp_ph_q;
	logic signed [PW-1:0] sx_s1, sy_s1, sz_s1;
	logic [PW-2:0] ax_s1, ay_s1, az_s1;
	logic [60:0] ssq_s2;
	logic        big_s1, big_s2;
	logic [29:0] rq;
	logic [TW-1:0] t_cur;
	logic signed [TW+16:0] mx, my, mz;
	logic [59:0] sqx, sqy, rq_sq;
	logic [16:0] ax0, ay0, az0;
	logic [35:0] trial;
	logic [16:0] r_rnd;
	logic [16:0] distz, distr, wall;
	logic [33:0] rr;

	assign c_eff = (coarse_step_mm == 8'd0) ? 8'd1 : coarse_step_mm;
	assign f_eff = (fine_step_mm == 8'd0) ? 8'd1 : fine_step_mm;
	assign rq = {radius_mm, 15'd0};
	assign rq_sq = rq * rq;
	assign t_cur = cmd.sel_fine ? base_q + tp_q : t_q;
	assign mx = $signed({1'b0, t_cur}) * dx_q;
	assign my = $signed({1'b0, t_cur}) * dy_q;
	assign mz = $signed({1'b0, t_cur}) * dz_q;
	assign ax0 = px_q[16] ? 17'(-px_q) : 17'(px_q);
	assign ay0 = py_q[16] ? 17'(-py_q) : 17'(py_q);
	assign az0 = pz_q[16] ? 17'(-pz_q) : 17'(pz_q);
	assign rr = 34'(radius_mm) * 34'(radius_mm);
	// One result bit per cycle of the restoring square root.
	assign trial = {rem_q[33:0], s_q[33:32]} - 36'({root_q, 2'b01});

	always_comb begin
		r_rnd = root_q;
		if (s_q - 34'(root_q) * 34'(root_q) > 34'(root_q))
			r_rnd = root_q + 17'd1;
		distz = (az0 > 17'(half_height_mm)) ? az0 - 17'(half_height_mm)
			: 17'(half_height_mm) - az0;
		distr = (r_rnd > 17'(radius_mm)) ? r_rnd - 17'(radius_mm)
			: 17'(radius_mm) - r_rnd;
		wall = (distz < distr) ? distz : distr;
		if (wall > OutSat)
			wall = OutSat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			smp_ph_q <= 2'd0;
			sq_cnt_q <= 5'd0;
		end else begin
			strobe <= cmd.emit;
			if (cmd.load) begin
				sq_cnt_q <= 5'd17;
			end else if (cmd.sqrt_step && sq_cnt_q != 5'd0) begin
				sq_cnt_q <= sq_cnt_q - 5'd1;
			end
			if (cmd.sample) begin
				smp_ph_q <= 2'd1;
			end else if (smp_ph_q == 2'd1) begin
				smp_ph_q <= 2'd2;
			end else begin
				smp_ph_q <= 2'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pos_x; py_q <= pos_y; pz_q <= pos_z;
			dx_q <= dir_x; dy_q <= dir_y; dz_q <= dir_z;
			s_q <= 34'(pos_x[16] ? 17'(-pos_x) : 17'(pos_x))
				* 34'(pos_x[16] ? 17'(-pos_x) : 17'(pos_x))
				+ 34'(pos_y[16] ? 17'(-pos_y) : 17'(pos_y))
				* 34'(pos_y[16] ? 17'(-pos_y) : 17'(pos_y));
			root_q <= 17'd0;
			t_q <= '0;
		end else if (cmd.sqrt_step && sq_cnt_q != 5'd0) begin
			if (!trial[35]) begin
				rem_q <= trial[33:0];
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], s_q[33:32]};
				root_q <= {root_q[15:0], 1'b0};
			end
		end
		if (cmd.load) begin
			rem_q <= '0;
		end
		if (cmd.sqrt_step && sq_cnt_q != 5'd0) begin
			s_q <= {s_q[31:0], s_q[33:32]};
		end
		if (cmd.wall_calc) begin
			outside_q <= (s_q > rr) || (az0 > 17'(half_height_mm));
			wall_dist <= ((s_q > rr) || (az0 > 17'(half_height_mm))) ? 17'(-wall) : wall;
		end
		if (cmd.step_coarse) t_q <= t_q + TW'(c_eff);
		if (cmd.set_fine_base) begin
			base_q <= t_q - TW'(c_eff);
			tp_q <= TW'(f_eff);
		end
		if (cmd.step_fine) tp_q <= tp_q + TW'(f_eff);
		if (cmd.sample) begin
			sx_s1 <= PW'(px_q) * (PW'(1) <<< 15) + PW'(mx);
			sy_s1 <= PW'(py_q) * (PW'(1) <<< 15) + PW'(my);
			sz_s1 <= PW'(pz_q) * (PW'(1) <<< 15) + PW'(mz);
		end
		if (smp_ph_q == 2'd1) begin
			ssq_s2 <= 61'(sqx) + 61'(sqy);
			big_s2 <= big_s1;
		end
		if (cmd.emit) begin
			is_outside <= outside_q;
			if (outside_q) ray_dist <= wall_dist;
			else if (cmd.set_nofind) ray_dist <= (TMax > TW'(OutSat)) ? OutSat : 17'(TMax);
			else if (base_q + tp_q > TW'(OutSat)) ray_dist <= OutSat;
			else ray_dist <= 17'(base_q + tp_q);
		end
	end

	assign ax_s1 = sx_s1[PW-1] ? (PW-1)'(-sx_s1) : (PW-1)'(sx_s1);
	assign ay_s1 = sy_s1[PW-1] ? (PW-1)'(-sy_s1) : (PW-1)'(sy_s1);
	assign az_s1 = sz_s1[PW-1] ? (PW-1)'(-sz_s1) : (PW-1)'(sz_s1);
	assign big_s1 = (az_s1 > (PW-1)'({half_height_mm, 15'd0})) ||
		(ax_s1 > (PW-1)'(rq)) || (ay_s1 > (PW-1)'(rq));
	// The squares only matter when both magnitudes are within the radius.
	assign sqx = ax_s1[29:0] * ax_s1[29:0];
	assign sqy = ay_s1[29:0] * ay_s1[29:0];

	assign stat.sqrt_done = (sq_cnt_q == 5'd0);
	assign stat.outside = outside_q;
	assign stat.sample_ready = (smp_ph_q == 2'd2);
	assign stat.sample_out = big_s2 || (ssq_s2 > 61'(rq_sq));
	assign stat.t_limit = (t_q >= TMax);
endmodule

// ===== hdl/cwd_ctrl.sv =====
// Controller state machine that sequences root, wall distance and the two ray marches.
module cwd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output cwd_pkg::cwd_cmd_t  cmd,
	input  cwd_pkg::cwd_stat_t stat
);
	import cwd_pkg::*;

	typedef enum logic [2:0] {
		IDLE, ROOT, WALL, COARSE, COARSE_W, FINE, FINE_W, DONE
	} state_t;

	state_t state_q;
	logic   nofind_q;

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == IDLE) && start;
		cmd.sqrt_step = (state_q == ROOT);
		cmd.wall_calc = (state_q == WALL);
		cmd.sample = (state_q == COARSE) || (state_q == FINE);
		cmd.sel_fine = (state_q == FINE);
		cmd.step_coarse = (state_q == COARSE_W) && stat.sample_ready && !stat.sample_out;
		cmd.set_fine_base = (state_q == COARSE_W) && stat.sample_ready && stat.sample_out;
		cmd.step_fine = (state_q == FINE_W) && stat.sample_ready && !stat.sample_out;
		cmd.set_nofind = nofind_q;
		cmd.emit = (state_q == DONE);
	end

	assign busy = (state_q != IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			nofind_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					nofind_q <= 1'b0;
					if (start) state_q <= ROOT;
				end
				ROOT: if (stat.sqrt_done) state_q <= WALL;
				WALL: state_q <= COARSE;
				COARSE: begin
					if (stat.outside) begin
						state_q <= DONE;
					end else if (stat.t_limit) begin
						nofind_q <= 1'b1;
						state_q <= DONE;
					end else begin
						state_q <= COARSE_W;
					end
				end
				COARSE_W: begin
					if (stat.sample_ready) state_q <= stat.sample_out ? FINE : COARSE;
				end
				FINE: state_q <= FINE_W;
				FINE_W: begin
					if (stat.sample_ready) state_q <= stat.sample_out ? DONE : FINE;
				end
				DONE: state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/cylinder_wall_distance.sv =====
// Top level of the cylinder wall distance block with configuration registers.
// Usage: pulse start while busy is low with a vertex (pos_x/y/z, mm) and a
// unit direction (dir_x/y/z, Q1.15); the word is taken at that edge.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// Each result word appears for one cycle with strobe high: wall_dist,
// ray_dist and is_outside. The receiver cannot stall the block.
// Sequence: a bit serial square root and the wall distance, then coarse samples
// and then fine samples of the ray. A vertex that is outside finishes after
// the wall distance without marching the ray. Inside, the run time grows with
// ray_dist / coarse_step_mm and coarse_step_mm / fine_step_mm and is set by the
// shared sample tester, which handles one sample at a time.
// One word is processed at a time; busy stays high until the result strobe.
// Reset clears the controller and loads the default cylinder and steps.
module cylinder_wall_distance #(
	parameter int unsigned MAX_MARCH_MM = cwd_pkg::MaxMarchDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic signed [16:0] pos_x,
	input  logic signed [16:0] pos_y,
	input  logic signed [16:0] pos_z,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic               strobe,
	output logic signed [16:0] wall_dist,
	output logic signed [16:0] ray_dist,
	output logic               is_outside
);
	import cwd_pkg::*;

	logic [14:0] radius_q, half_height_q;
	logic [7:0]  coarse_q, fine_q;
	cwd_cmd_t    cmd;
	cwd_stat_t   stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadiusReset;
			half_height_q <= HalfHeightReset;
			coarse_q <= CoarseReset;
			fine_q <= FineReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegRadius: radius_q <= cfg_data;
				RegHalfHeight: half_height_q <= cfg_data;
				RegCoarse: coarse_q <= cfg_data[7:0];
				RegFine: fine_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	cwd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat)
	);

	cwd_datapath #(.MAX_MARCH_MM(MAX_MARCH_MM)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.radius_mm(radius_q), .half_height_mm(half_height_q),
		.coarse_step_mm(coarse_q), .fine_step_mm(fine_q),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.strobe(strobe), .wall_dist(wall_dist), .ray_dist(ray_dist),
		.is_outside(is_outside)
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result without work");
	a_ray_outside: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_outside |-> ray_dist == wall_dist) else $error("ray mismatch");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
endmodule
